>>> hdl/tlv_object_stream_parser_core_defines.svh
`ifndef TLV_OBJECT_STREAM_PARSER_CORE_DEFINES_SVH
`define TLV_OBJECT_STREAM_PARSER_CORE_DEFINES_SVH

// Both macros expect clk and arst_n in the scope where they are used.
`define TLVP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define TLVP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> hdl/tlvp_pkg.sv
package tlvp_pkg;

	localparam int BYTE_W = 8;
	localparam int ACC_W  = 32;

	localparam int MAX_TAG_BYTES_DEF    = 4;
	localparam int MAX_LENGTH_BYTES_DEF = 4;

	localparam int QDEPTH = 2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_TAG_MULTI   = 2'd0;
	localparam logic [1:0] CFG_TAG_MORE    = 2'd1;
	localparam logic [1:0] CFG_LENGTH_LONG = 2'd2;

	localparam logic [BYTE_W-1:0] TAG_MULTI_RST   = 8'h1F;
	localparam logic [BYTE_W-1:0] TAG_MORE_RST    = 8'h80;
	localparam logic [BYTE_W-1:0] LENGTH_LONG_RST = 8'h80;

	localparam logic [1:0] ROLE_TAG   = 2'd0;
	localparam logic [1:0] ROLE_LEN   = 2'd1;
	localparam logic [1:0] ROLE_VALUE = 2'd2;
	localparam logic [1:0] ROLE_SKIP  = 2'd3;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_TRUNC     = 3'd1;
	localparam logic [2:0] ERR_LEN_LONG  = 3'd2;
	localparam logic [2:0] ERR_OVERRUN   = 3'd3;
	localparam logic [2:0] ERR_TAG_LONG  = 3'd4;

	// Byte after classification in the front end.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] total;
		logic [BYTE_W-1:0] pos;
		logic              last;
		logic              tag_multi_hit;
		logic              tag_more_hit;
		logic              len_long_hit;
		logic [BYTE_W-1:0] len_cnt;
	} item_t;

	typedef struct packed {
		logic [1:0]        byte_role;
		logic [BYTE_W-1:0] byte_out;
		logic [BYTE_W-1:0] object_number;
		logic              header_done;
		logic [ACC_W-1:0]  tag_value;
		logic [2:0]        tag_bytes;
		logic [2:0]        length_bytes;
		logic [BYTE_W-1:0] value_length;
		logic [BYTE_W-1:0] value_offset;
		logic [2:0]        error_code;
		logic              end_of_field;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> hdl/tlv_object_stream_parser_core.sv
// Byte-serial TLV parser for a command data field. It takes one byte per cycle,
// unless in_stall is set, with the field's total length and returns one labelled
// beat per byte, in order: role (tag, length, value or skipped after an error),
// object ordinal, the header fields on the byte that completes a header, an error
// code and an end-of-field flag. A front end tracks the field position and matches
// the configured masks, a two-entry queue decouples it from the back end, whose
// per-byte state update sets the sustained rate of one byte per cycle unless
// out_stall; a byte's beat is registered when the back end pops it. Configuration
// writes are always taken and must only be made while no beat is in flight.
`include "tlv_object_stream_parser_core_defines.svh"

module tlv_object_stream_parser_core import tlvp_pkg::*; #(
	parameter int MAX_TAG_BYTES    = MAX_TAG_BYTES_DEF,
	parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [BYTE_W-1:0] total_length,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [BYTE_W-1:0] cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        byte_role,
	output logic [BYTE_W-1:0] byte_out,
	output logic [BYTE_W-1:0] object_number,
	output logic              header_done,
	output logic [ACC_W-1:0]  tag_value,
	output logic [2:0]        tag_bytes,
	output logic [2:0]        length_bytes,
	output logic [BYTE_W-1:0] value_length,
	output logic [BYTE_W-1:0] value_offset,
	output logic [2:0]        error_code,
	output logic              end_of_field
);

	logic      push;
	item_t     push_item;
	item_t     head;
	logic      head_valid;
	logic      pop;
	q_status_t q_status;
	result_t   result;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_status.full;

	tlvp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.total_length (total_length),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.item         (push_item)
	);

	tlvp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.status     (q_status)
	);

	tlvp_back #(
		.MAX_TAG_BYTES    (MAX_TAG_BYTES),
		.MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result)
	);

	assign byte_role     = result.byte_role;
	assign byte_out      = result.byte_out;
	assign object_number = result.object_number;
	assign header_done   = result.header_done;
	assign tag_value     = result.tag_value;
	assign tag_bytes     = result.tag_bytes;
	assign length_bytes  = result.length_bytes;
	assign value_length  = result.value_length;
	assign value_offset  = result.value_offset;
	assign error_code    = result.error_code;
	assign end_of_field  = result.end_of_field;

	`TLVP_ASSERT_NEVER(a_queue_state, q_status.full && q_status.empty, "queue full and empty")
	`TLVP_ASSERT_IMP(a_hdr_on_len, out_valid && header_done, byte_role == ROLE_LEN && error_code == ERR_NONE, "header done off a clean length byte")
	`TLVP_ASSERT_IMP(a_skip_clean, out_valid && byte_role == ROLE_SKIP, error_code == ERR_NONE && !header_done, "skipped byte carries status")
	`TLVP_ASSERT_IMP(a_hdr_fields, out_valid && !header_done, tag_value == '0 && tag_bytes == '0 && value_length == '0, "header fields without header")

endmodule

>>> hdl/tlvp_front.sv
module tlvp_front import tlvp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [BYTE_W-1:0] total_length,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [BYTE_W-1:0] cfg_data,
	output logic              push,
	output item_t             item
);

	logic [BYTE_W-1:0] tag_multi_mask_q;
	logic [BYTE_W-1:0] tag_more_mask_q;
	logic [BYTE_W-1:0] length_long_mask_q;
	logic [BYTE_W-1:0] position_q;
	logic [BYTE_W:0]   pos_inc;
	logic              last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_multi_mask_q   <= TAG_MULTI_RST;
			tag_more_mask_q    <= TAG_MORE_RST;
			length_long_mask_q <= LENGTH_LONG_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TAG_MULTI:   tag_multi_mask_q   <= cfg_data;
				CFG_TAG_MORE:    tag_more_mask_q    <= cfg_data;
				CFG_LENGTH_LONG: length_long_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The field position depends only on the byte count, so it is tracked here.
	assign pos_inc = {1'b0, position_q} + 9'd1;
	assign last    = (pos_inc >= {1'b0, total_length});
	assign push    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
		end else if (push) begin
			position_q <= last ? '0 : pos_inc[BYTE_W-1:0];
		end
	end

	always_comb begin
		item.data          = data_byte;
		item.total         = total_length;
		item.pos           = position_q;
		item.last          = last;
		item.tag_multi_hit = ((data_byte & tag_multi_mask_q) == tag_multi_mask_q);
		item.tag_more_hit  = ((data_byte & tag_more_mask_q) != '0);
		item.len_long_hit  = ((data_byte & length_long_mask_q) == length_long_mask_q);
		item.len_cnt       = data_byte & ~length_long_mask_q;
	end

endmodule

>>> hdl/tlvp_queue.sv
module tlvp_queue import tlvp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  item_t     push_item,
	input  logic      pop,
	output item_t     head,
	output logic      head_valid,
	output q_status_t status
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	item_t         entries_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head         = entries_q[rd_ptr_q];
	assign head_valid   = (count_q != '0);
	assign status.full  = (count_q == CW'(QDEPTH));
	assign status.empty = (count_q == '0);

endmodule

>>> hdl/tlvp_back.sv
module tlvp_back import tlvp_pkg::*; #(
	parameter int MAX_TAG_BYTES    = MAX_TAG_BYTES_DEF,
	parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   head,
	input  logic    head_valid,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t result
);

	localparam int TCW = $clog2(MAX_TAG_BYTES + 1);
	localparam int LCW = $clog2(MAX_LENGTH_BYTES + 2);
	localparam int LNW = $clog2(MAX_LENGTH_BYTES + 1);

	localparam logic [2:0] PH_TAG_FIRST = 3'd0;
	localparam logic [2:0] PH_TAG_MORE  = 3'd1;
	localparam logic [2:0] PH_LEN_FIRST = 3'd2;
	localparam logic [2:0] PH_LEN_MORE  = 3'd3;
	localparam logic [2:0] PH_VALUE     = 3'd4;

	logic [2:0]        phase_q, phase_n;
	logic [BYTE_W-1:0] obj_q, obj_n;
	logic [ACC_W-1:0]  tag_acc_q, tag_acc_n;
	logic [TCW-1:0]    tag_cnt_q, tag_cnt_n;
	logic [LCW-1:0]    len_cnt_q, len_cnt_n;
	logic [LNW-1:0]    len_need_q, len_need_n;
	logic [ACC_W-1:0]  len_acc_q, len_acc_n;
	logic [BYTE_W-1:0] val_rem_q, val_rem_n;
	logic              err_seen_q, err_seen_n;

	logic [1:0]        role;
	logic [2:0]        err;
	logic              hdr;
	logic              do_finish;
	logic [BYTE_W:0]   pos_inc;
	logic [BYTE_W:0]   avail;
	logic [BYTE_W-1:0] tag_cnt_ext;
	logic [BYTE_W-1:0] len_cnt_ext;
	logic              out_valid_q;
	result_t           result_q;

	assign pop     = head_valid && (!out_valid_q || !out_stall);
	assign pos_inc = {1'b0, head.pos} + 9'd1;
	assign avail   = ({1'b0, head.total} > pos_inc) ? ({1'b0, head.total} - pos_inc) : '0;

	always_comb begin
		phase_n    = phase_q;
		obj_n      = obj_q;
		tag_acc_n  = tag_acc_q;
		tag_cnt_n  = tag_cnt_q;
		len_cnt_n  = len_cnt_q;
		len_need_n = len_need_q;
		len_acc_n  = len_acc_q;
		val_rem_n  = val_rem_q;
		err_seen_n = err_seen_q;
		role       = ROLE_SKIP;
		err        = ERR_NONE;
		hdr        = 1'b0;
		do_finish  = 1'b0;

		if (!err_seen_q) begin
			unique case (phase_q)
				PH_TAG_MORE: begin
					role      = ROLE_TAG;
					tag_acc_n = {tag_acc_q[ACC_W-BYTE_W-1:0], head.data};
					tag_cnt_n = tag_cnt_q + 1'b1;
					if (head.tag_more_hit) begin
						if (tag_cnt_n >= TCW'(MAX_TAG_BYTES)) begin
							err = ERR_TAG_LONG;
						end
					end else begin
						phase_n = PH_LEN_FIRST;
					end
				end
				PH_LEN_FIRST: begin
					role      = ROLE_LEN;
					len_cnt_n = LCW'(1);
					len_acc_n = '0;
					if (head.len_long_hit) begin
						if (head.len_cnt > BYTE_W'(MAX_LENGTH_BYTES)) begin
							err = ERR_LEN_LONG;
						end else if (head.len_cnt == '0) begin
							do_finish = 1'b1;
						end else begin
							len_need_n = LNW'(head.len_cnt);
							phase_n    = PH_LEN_MORE;
						end
					end else begin
						len_acc_n = ACC_W'(head.data);
						do_finish = 1'b1;
					end
				end
				PH_LEN_MORE: begin
					role      = ROLE_LEN;
					len_cnt_n = len_cnt_q + 1'b1;
					// An accumulator that would lose bits saturates, which always overruns.
					if (len_acc_q[ACC_W-1:ACC_W-BYTE_W] != '0) begin
						len_acc_n = '1;
					end else begin
						len_acc_n = {len_acc_q[ACC_W-BYTE_W-1:0], head.data};
					end
					len_need_n = len_need_q - 1'b1;
					do_finish  = (len_need_n == '0);
				end
				PH_VALUE: begin
					role      = ROLE_VALUE;
					val_rem_n = val_rem_q - 1'b1;
					if (val_rem_n == '0) begin
						phase_n = PH_TAG_FIRST;
						obj_n   = obj_q + 1'b1;
					end
				end
				default: begin
					role      = ROLE_TAG;
					tag_acc_n = ACC_W'(head.data);
					tag_cnt_n = TCW'(1);
					if (head.tag_multi_hit) begin
						if (MAX_TAG_BYTES <= 1) begin
							err = ERR_TAG_LONG;
						end else begin
							phase_n = PH_TAG_MORE;
						end
					end else begin
						phase_n = PH_LEN_FIRST;
					end
				end
			endcase

			if (do_finish) begin
				if (len_acc_n > ACC_W'(avail)) begin
					err = ERR_OVERRUN;
				end else begin
					hdr = 1'b1;
					if (len_acc_n == '0) begin
						phase_n = PH_TAG_FIRST;
						obj_n   = obj_q + 1'b1;
					end else begin
						phase_n   = PH_VALUE;
						val_rem_n = len_acc_n[BYTE_W-1:0];
					end
				end
			end

			if (err == ERR_NONE && head.last && phase_n != PH_TAG_FIRST) begin
				err = ERR_TRUNC;
			end
			if (err != ERR_NONE) begin
				err_seen_n = 1'b1;
			end
		end
	end

	assign tag_cnt_ext = BYTE_W'(tag_cnt_n);
	assign len_cnt_ext = BYTE_W'(len_cnt_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TAG_FIRST;
			obj_q      <= 8'd1;
			tag_acc_q  <= '0;
			tag_cnt_q  <= '0;
			len_cnt_q  <= '0;
			len_need_q <= '0;
			len_acc_q  <= '0;
			val_rem_q  <= '0;
			err_seen_q <= 1'b0;
		end else if (pop) begin
			// The last byte of a field returns everything to the start state.
			if (head.last) begin
				phase_q    <= PH_TAG_FIRST;
				obj_q      <= 8'd1;
				tag_acc_q  <= '0;
				tag_cnt_q  <= '0;
				len_cnt_q  <= '0;
				len_need_q <= '0;
				len_acc_q  <= '0;
				val_rem_q  <= '0;
				err_seen_q <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				obj_q      <= obj_n;
				tag_acc_q  <= tag_acc_n;
				tag_cnt_q  <= tag_cnt_n;
				len_cnt_q  <= len_cnt_n;
				len_need_q <= len_need_n;
				len_acc_q  <= len_acc_n;
				val_rem_q  <= val_rem_n;
				err_seen_q <= err_seen_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.byte_role     <= role;
			result_q.byte_out      <= head.data;
			result_q.object_number <= obj_q;
			result_q.header_done   <= hdr;
			result_q.tag_value     <= hdr ? tag_acc_n : '0;
			result_q.tag_bytes     <= hdr ? tag_cnt_ext[2:0] : '0;
			result_q.length_bytes  <= hdr ? len_cnt_ext[2:0] : '0;
			result_q.value_length  <= hdr ? len_acc_n[BYTE_W-1:0] : '0;
			result_q.value_offset  <= hdr ? pos_inc[BYTE_W-1:0] : '0;
			result_q.error_code    <= err;
			result_q.end_of_field  <= head.last;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule
